// File: rtl/ps2km_pkg.sv
// shared types and constants for the ps2 scan code key matrix
`timescale 1ns / 1ps
package ps2km_pkg;

  localparam int ROW_COUNT = 24;
  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int KEY_W     = 10;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] K_F0 = 8'hF0;
  localparam logic [7:0] K_E0 = 8'hE0;
  localparam logic [7:0] K_E1 = 8'hE1;
  localparam logic [7:0] K_12 = 8'h12;
  localparam logic [7:0] K_14 = 8'h14;

  localparam logic [1:0] BASE_PLAIN = 2'b00;
  localparam logic [1:0] BASE_E0    = 2'b01;
  localparam logic [1:0] BASE_E1    = 2'b10;

  typedef enum logic [3:0] {
    P_NORMAL = 4'd0,
    P_F0     = 4'd1,
    P_F0_12  = 4'd2,
    P_E0     = 4'd3,
    P_E0_F0  = 4'd4,
    P_E1     = 4'd5,
    P_E1_F0  = 4'd6,
    P_S12    = 4'd7,
    P_S12_F0 = 4'd8
  } pst_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_MAKE  = 2'd1,
    EV_BREAK = 2'd2
  } evk_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic [4:0] row_index;
  } in_t;

  typedef struct packed {
    logic [31:0]      row_bits;
    logic [1:0]       event_kind;
    logic [KEY_W-1:0] key_code;
    logic [3:0]       parser_state;
  } out_t;

  typedef struct packed {
    evk_t             kind;
    logic [KEY_W-1:0] key;
  } pev_t;

endpackage

// File: rtl/ps2km_parser.sv
// prefix parser state machine for scan code set 2 bytes
`timescale 1ns / 1ps
module ps2km_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output ps2km_pkg::pev_t  ev,
  output ps2km_pkg::pst_t  state
);

  ps2km_pkg::pst_t state_r;
  ps2km_pkg::pst_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ps2km_pkg::P_NORMAL;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic [1:0]      base;
    ps2km_pkg::evk_t kind;
    base      = ps2km_pkg::BASE_PLAIN;
    kind      = ps2km_pkg::EV_NONE;
    state_nxt = state_r;
    case (state_r)
      ps2km_pkg::P_F0: begin
        if (rx_byte == ps2km_pkg::K_12) begin
          state_nxt = ps2km_pkg::P_F0_12;
        end else begin
          kind      = ps2km_pkg::EV_BREAK;
          state_nxt = ps2km_pkg::P_NORMAL;
        end
      end
      ps2km_pkg::P_F0_12, ps2km_pkg::P_S12_F0: begin
        if (!(rx_byte inside {ps2km_pkg::K_12, ps2km_pkg::K_F0})) begin
          kind      = ps2km_pkg::EV_BREAK;
          base      = ps2km_pkg::BASE_E1;
          state_nxt = ps2km_pkg::P_NORMAL;
        end
      end
      ps2km_pkg::P_E0: begin
        if (rx_byte == ps2km_pkg::K_F0) begin
          state_nxt = ps2km_pkg::P_E0_F0;
        end else if (rx_byte == ps2km_pkg::K_12) begin
          state_nxt = ps2km_pkg::P_NORMAL;
        end else begin
          kind      = ps2km_pkg::EV_MAKE;
          base      = ps2km_pkg::BASE_E0;
          state_nxt = ps2km_pkg::P_NORMAL;
        end
      end
      ps2km_pkg::P_E0_F0: begin
        state_nxt = ps2km_pkg::P_NORMAL;
        if (rx_byte != ps2km_pkg::K_12) begin
          kind = ps2km_pkg::EV_BREAK;
          base = ps2km_pkg::BASE_E0;
        end
      end
      ps2km_pkg::P_E1: begin
        if (rx_byte == ps2km_pkg::K_F0) begin
          state_nxt = ps2km_pkg::P_E1_F0;
        end else if (rx_byte != ps2km_pkg::K_14) begin
          kind      = ps2km_pkg::EV_MAKE;
          base      = ps2km_pkg::BASE_E1;
          state_nxt = ps2km_pkg::P_NORMAL;
        end
      end
      ps2km_pkg::P_E1_F0: begin
        if (rx_byte == ps2km_pkg::K_14) begin
          state_nxt = ps2km_pkg::P_E1;
        end else begin
          kind      = ps2km_pkg::EV_BREAK;
          base      = ps2km_pkg::BASE_E1;
          state_nxt = ps2km_pkg::P_NORMAL;
        end
      end
      ps2km_pkg::P_S12: begin
        if (rx_byte == ps2km_pkg::K_F0) begin
          state_nxt = ps2km_pkg::P_S12_F0;
        end else if (rx_byte != ps2km_pkg::K_12) begin
          kind      = ps2km_pkg::EV_MAKE;
          base      = ps2km_pkg::BASE_E1;
          state_nxt = ps2km_pkg::P_NORMAL;
        end
      end
      default: begin
        if (rx_byte == ps2km_pkg::K_F0) begin
          state_nxt = ps2km_pkg::P_F0;
        end else if (rx_byte == ps2km_pkg::K_E0) begin
          state_nxt = ps2km_pkg::P_E0;
        end else if (rx_byte == ps2km_pkg::K_E1) begin
          state_nxt = ps2km_pkg::P_E1;
        end else if (rx_byte == ps2km_pkg::K_12) begin
          state_nxt = ps2km_pkg::P_S12;
        end else begin
          kind      = ps2km_pkg::EV_MAKE;
          state_nxt = ps2km_pkg::P_NORMAL;
        end
      end
    endcase
    ev.kind = kind;
    ev.key  = (kind == ps2km_pkg::EV_NONE) ? '0 : {base, rx_byte};
  end

  assign state = state_r;

endmodule

// File: rtl/ps2km_row_ram.sv
// key matrix row memory with per-row valid bits cleared at reset
`timescale 1ns / 1ps
module ps2km_row_ram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [ps2km_pkg::ROW_W-1:0] rd_addr,
  output logic [31:0]                rd_data,
  input  logic                       wr_en,
  input  logic [ps2km_pkg::ROW_W-1:0] wr_addr,
  input  logic [31:0]                wr_data
);

  logic [31:0]                    mem [ps2km_pkg::ROW_COUNT];
  logic [ps2km_pkg::ROW_COUNT-1:0] vld_r;
  logic [31:0]                    rd_data_r;
  logic                           rd_vld_r;
  logic                           rd_ok;
  logic                           wr_ok;

  assign rd_ok = int'(rd_addr) < ps2km_pkg::ROW_COUNT;
  assign wr_ok = int'(wr_addr) < ps2km_pkg::ROW_COUNT;

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en && rd_ok) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en && wr_ok) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= rd_ok && vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// File: rtl/ps2_scancode_key_matrix.sv
// top level: ps2 scan code set 2 decoder keeping a key matrix
//
// channel   ports                        direction  handshake
// request   start, busy, in_req          in         start && !busy
// result    out_valid, out_rsp           out        out_valid, one cycle
//
// a request is taken when start is high and busy is low; its result appears in the next cycle
// the row memory is read when a request is taken and written back while its result is shown
// busy is high while a result is pending, so no new request is taken while the last result is shown
// after reset the matrix reads as all zeros at once; no clearing pass
// the receiver cannot stall; results are shown for exactly one cycle
`timescale 1ns / 1ps
module ps2_scancode_key_matrix (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ps2km_pkg::in_t   in_req,
  output logic             out_valid,
  output ps2km_pkg::out_t  out_rsp
);

  logic                            accept;
  logic                            step;
  ps2km_pkg::pev_t                 ev;
  ps2km_pkg::pst_t                 pstate;
  logic [ps2km_pkg::ROW_W-1:0]     rd_addr;
  logic [31:0]                     rd_data;
  logic                            wr_en;
  logic [31:0]                     wr_data;
  logic [31:0]                     bit_mask;

  logic                            pend_r;
  logic                            op_r;
  ps2km_pkg::pev_t                 ev_r;

  assign accept = start && !busy;
  assign step   = accept && (in_req.opcode == ps2km_pkg::OP_BYTE) && (in_req.rx_byte != '0);

  ps2km_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_req.rx_byte),
    .ev      (ev),
    .state   (pstate)
  );

  assign rd_addr = (in_req.opcode == ps2km_pkg::OP_READ)
                 ? in_req.row_index[ps2km_pkg::ROW_W-1:0]
                 : ev.key[5 +: ps2km_pkg::ROW_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_req.opcode;
      if (step) begin
        ev_r <= ev;
      end else begin
        ev_r.kind <= ps2km_pkg::EV_NONE;
        ev_r.key  <= '0;
      end
    end
  end

  // row reads above the matrix come back as zero
  logic rd_in_range;
  assign rd_in_range = (in_req.opcode == ps2km_pkg::OP_BYTE)
                    || (int'(in_req.row_index) < ps2km_pkg::ROW_COUNT);

  ps2km_row_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && rd_in_range),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (ev_r.key[5 +: ps2km_pkg::ROW_W]),
    .wr_data (wr_data)
  );

  logic rd_in_range_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_in_range_r <= rd_in_range;
    end
  end

  assign bit_mask = 32'(1) << ev_r.key[4:0];
  assign wr_en    = pend_r && (op_r == ps2km_pkg::OP_BYTE)
                 && (ev_r.kind != ps2km_pkg::EV_NONE)
                 && (int'(ev_r.key[9:5]) < ps2km_pkg::ROW_COUNT);
  assign wr_data  = (ev_r.kind == ps2km_pkg::EV_MAKE) ? (rd_data | bit_mask)
                                                      : (rd_data & ~bit_mask);

  assign busy      = pend_r;
  assign out_valid = pend_r;

  always_comb begin
    out_rsp.row_bits     = ((op_r == ps2km_pkg::OP_READ) && rd_in_range_r) ? rd_data : '0;
    out_rsp.event_kind   = ev_r.kind;
    out_rsp.key_code     = ev_r.key;
    out_rsp.parser_state = pstate;
  end

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without a request");

  a_no_event_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.event_kind == ps2km_pkg::EV_NONE) |-> out_rsp.key_code == '0)
    else $error("key code reported without an event");

  a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r == ps2km_pkg::OP_READ) |->
      (out_rsp.event_kind == ps2km_pkg::EV_NONE && $stable(pstate)))
    else $error("row read changed parser state or raised an event");

  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && op_r == ps2km_pkg::OP_READ) |-> !wr_en)
    else $error("row read wrote the matrix");

endmodule

// File: test/testbench.sv
// self-checking testbench for the ps2 scan code key matrix decoder
`timescale 1ns / 1ps
module testbench;
  import ps2km_pkg::*;

  class keymap_model;
    logic [31:0] rows [ROW_COUNT];
    pst_t        prefix;
    out_t        expected_rsp [$];
    int          errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      prefix = P_NORMAL;
      errors = 0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function void take_request(in_t r);
      out_t             e;
      pst_t             nxt;
      evk_t             kind;
      logic [KEY_W-1:0] base;
      logic [KEY_W-1:0] key;
      logic [7:0]       b;
      logic             fin;
      e    = '0;
      kind = EV_NONE;
      key  = '0;
      base = '0;
      fin  = 1'b0;
      b    = r.rx_byte;
      nxt  = prefix;
      if (r.opcode == OP_READ) begin
        if (r.row_index < ROW_COUNT) e.row_bits = rows[r.row_index];
      end else if (b != 8'h00) begin
        case (prefix)
          P_F0: begin
            if (b == K_12) nxt = P_F0_12;
            else begin kind = EV_BREAK; fin = 1'b1; end
          end
          P_F0_12, P_S12_F0: begin
            if (b != K_12 && b != K_F0) begin
              kind = EV_BREAK; base = 10'h200; fin = 1'b1;
            end
          end
          P_E0: begin
            if (b == K_F0) nxt = P_E0_F0;
            else if (b == K_12) fin = 1'b1;
            else begin kind = EV_MAKE; base = 10'h100; fin = 1'b1; end
          end
          P_E0_F0: begin
            if (b == K_12) fin = 1'b1;
            else begin kind = EV_BREAK; base = 10'h100; fin = 1'b1; end
          end
          P_E1: begin
            if (b == K_F0) nxt = P_E1_F0;
            else if (b != K_14) begin kind = EV_MAKE; base = 10'h200; fin = 1'b1; end
          end
          P_E1_F0: begin
            if (b == K_14) nxt = P_E1;
            else begin kind = EV_BREAK; base = 10'h200; fin = 1'b1; end
          end
          P_S12: begin
            if (b == K_F0) nxt = P_S12_F0;
            else if (b != K_12) begin kind = EV_MAKE; base = 10'h200; fin = 1'b1; end
          end
          default: begin
            if (b == K_F0) nxt = P_F0;
            else if (b == K_E0) nxt = P_E0;
            else if (b == K_E1) nxt = P_E1;
            else if (b == K_12) nxt = P_S12;
            else begin kind = EV_MAKE; fin = 1'b1; end
          end
        endcase
        if (kind != EV_NONE) begin
          key = base | {2'b00, b};
          if (key[9:5] < ROW_COUNT) rows[key[9:5]][key[4:0]] = (kind == EV_MAKE);
        end
        if (fin) nxt = P_NORMAL;
        prefix = nxt;
      end
      e.event_kind   = kind;
      e.key_code     = key;
      e.parser_state = prefix;
      expected_rsp.push_back(e);
    endfunction

    function void check_result(out_t a);
      out_t e;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (a.row_bits !== e.row_bits) begin
        $display("%0t: row_bits expected %h actual %h", $time, e.row_bits, a.row_bits);
        errors++;
      end
      if (a.event_kind !== e.event_kind) begin
        $display("%0t: event_kind expected %0d actual %0d", $time, e.event_kind,
                 a.event_kind);
        errors++;
      end
      if (a.key_code !== e.key_code) begin
        $display("%0t: key_code expected %h actual %h", $time, e.key_code, a.key_code);
        errors++;
      end
      if (a.parser_state !== e.parser_state) begin
        $display("%0t: parser_state expected %0d actual %0d", $time, e.parser_state,
                 a.parser_state);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_req = '0;
  logic out_valid;
  out_t out_rsp;

  keymap_model sb = new();
  int burst_left = 0;
  int sent = 0;

  ps2_scancode_key_matrix dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_rsp);
  end

  task automatic idle(input int n);
    logic [13:0] junk;
    junk = 14'($urandom);
    if (n > 0) begin
      @(negedge clk);
      start  <= 1'b0;
      in_req <= junk;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send(input in_t r);
    if (burst_left == 0) begin
      idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    sb.take_request(r);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_t r;
    r.opcode    = OP_BYTE;
    r.rx_byte   = b;
    r.row_index = 5'($urandom_range(0, 31));
    send(r);
  endtask

  task automatic send_read(input logic [4:0] row);
    in_t r;
    r.opcode    = OP_READ;
    r.rx_byte   = 8'($urandom_range(0, 255));
    r.row_index = row;
    send(r);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] codes [6];
    codes = '{K_F0, K_E0, K_E1, K_12, K_14, 8'h00};
    if ($urandom_range(0, 9) == 0) return codes[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic key_seq(input int kind, input logic [7:0] b);
    case (kind)
      0: send_byte(b);
      1: begin send_byte(K_F0); send_byte(b); end
      2: begin send_byte(K_E0); send_byte(b); end
      3: begin send_byte(K_E0); send_byte(K_F0); send_byte(b); end
      4: begin
        send_byte(K_E1);
        repeat ($urandom_range(0, 2)) send_byte(K_14);
        send_byte(b);
      end
      5: begin
        send_byte(K_E1); send_byte(K_F0);
        if ($urandom_range(0, 1)) begin send_byte(K_14); send_byte(K_F0); end
        send_byte(b);
      end
      6: begin
        send_byte(K_12);
        repeat ($urandom_range(0, 2)) send_byte(K_12);
        send_byte(b);
      end
      7: begin
        send_byte(K_12); send_byte(K_F0);
        repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? K_12 : K_F0);
        send_byte(b);
      end
      default: begin
        send_byte(K_F0); send_byte(K_12);
        repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? K_12 : K_F0);
        send_byte(b);
      end
    endcase
  endtask

  initial begin
    int sel;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_read(5'd0);
    send_read(5'd31);
    send_byte(8'h00);
    key_seq(0, 8'hFF);
    key_seq(0, 8'hFF);
    key_seq(1, 8'hFF);
    key_seq(1, 8'hFF);
    key_seq(2, 8'hFF);
    key_seq(3, 8'h01);
    key_seq(2, K_12);
    key_seq(3, K_12);
    key_seq(4, 8'hFF);
    key_seq(5, 8'h80);
    key_seq(6, 8'hFF);
    key_seq(7, 8'h7F);
    key_seq(8, 8'h01);
    send_read(5'd23);
    send_read(5'd24);
    send_read(5'd7);
    drain();

    while (sent < 850) begin
      if (sent > 450 && sent < 470) drain();
      sel = $urandom_range(0, 19);
      if (sel < 3) send_read(5'($urandom_range(0, 31)));
      else if (sel < 5) send_byte(pick_byte());
      else key_seq($urandom_range(0, 8), pick_byte());
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ps2_scancode_key_matrix regression: pass");
    end else begin
      $display("ps2_scancode_key_matrix regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("ps2_scancode_key_matrix regression: fail");
    $finish;
  end

endmodule
